[hw/rtl/sos_pkg.sv]
// Shared constants, codes and types for the set-of-stacks engine.
// Used by sos_chain, set_of_stacks_engine and sos_checker.
package sos_pkg;

    localparam int NUM_SUBSTACKS  = 16;
    localparam int SUBSTACK_DEPTH = 64;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;

    localparam int SUB_W  = (NUM_SUBSTACKS > 1) ? $clog2(NUM_SUBSTACKS) : 1;
    localparam int USE_W  = $clog2(NUM_SUBSTACKS + 1);
    localparam int FILL_W = $clog2(SUBSTACK_DEPTH + 1);
    localparam int STORE_DEPTH = NUM_SUBSTACKS * SUBSTACK_DEPTH;
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TOP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_AT = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SUCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic                we;
        logic                re;
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
    } sos_op_t;

    function automatic logic [ADDR_W-1:0] slot(input logic [SUB_W-1:0] s,
                                               input logic [FILL_W-1:0] k);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(s) * ADDR_W'(SUBSTACK_DEPTH);
        return base + ADDR_W'(k);
    endfunction

endpackage

[hw/rtl/sos_chain.sv]
// Chain bookkeeping: per-substack fill counts, chain length, size register,
// end-trim priority encoder and the store access for one command.
// Depends on sos_pkg.
module sos_chain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [sos_pkg::CMD_W-1:0]     cmd,
    input  logic [sos_pkg::IDX_W-1:0]     substack_index,
    input  logic                          cfg_wr_en,
    input  logic [sos_pkg::CFG_W-1:0]     cfg_wr_data,
    output sos_pkg::sos_op_t              op
);
    import sos_pkg::*;

    logic [FILL_W-1:0] fill_reg [NUM_SUBSTACKS];
    logic [FILL_W-1:0] fill_next [NUM_SUBSTACKS];
    logic [USE_W-1:0]  use_reg;
    logic [USE_W-1:0]  use_next;
    logic [CFG_W-1:0]  size_reg;
    logic [CFG_W-1:0]  size_next;

    logic [FILL_W-1:0] eff_size;
    logic [USE_W-1:0]  trim_len;
    logic [USE_W-1:0]  use_m1;
    logic [USE_W-1:0]  trim_m1;
    logic [SUB_W-1:0]  sel;
    logic [FILL_W-1:0] sel_fill;
    logic              need_new;

    always_comb
    begin
        if (size_reg == '0)
            eff_size = FILL_W'(1);
        else if (int'(size_reg) > SUBSTACK_DEPTH)
            eff_size = FILL_W'(SUBSTACK_DEPTH);
        else
            eff_size = FILL_W'(size_reg);
    end

    // Highest nonempty substack; substacks past the chain always read empty.
    always_comb
    begin
        trim_len = '0;
        for (int i = 0; i < NUM_SUBSTACKS; i++)
        begin
            if (fill_reg[i] != '0)
                trim_len = USE_W'(i + 1);
        end
    end

    assign use_m1  = use_reg - 1'b1;
    assign trim_m1 = trim_len - 1'b1;

    always_comb
    begin
        case (cmd)
            CMD_PUSH:         sel = use_m1[SUB_W-1:0];
            CMD_POP, CMD_TOP: sel = trim_m1[SUB_W-1:0];
            default:          sel = SUB_W'(substack_index);
        endcase
    end

    assign sel_fill = fill_reg[sel];
    assign need_new = (use_reg == '0) || (sel_fill >= eff_size);

    always_comb
    begin
        fill_next = fill_reg;
        use_next  = use_reg;
        size_next = cfg_wr_en ? cfg_wr_data : size_reg;
        op        = '0;
        op.status = ST_OK;
        if (go)
        begin
            case (cmd)
                CMD_PUSH:
                begin
                    if (need_new && int'(use_reg) >= NUM_SUBSTACKS)
                    begin
                        op.status = ST_FULL;
                    end
                    else if (need_new)
                    begin
                        use_next                       = use_reg + 1'b1;
                        fill_next[use_reg[SUB_W-1:0]]  = FILL_W'(1);
                        op.we                          = 1'b1;
                        op.addr = slot(use_reg[SUB_W-1:0], '0);
                    end
                    else
                    begin
                        fill_next[sel] = sel_fill + 1'b1;
                        op.we          = 1'b1;
                        op.addr        = slot(sel, sel_fill);
                    end
                end
                CMD_POP, CMD_TOP:
                begin
                    use_next = trim_len;
                    if (trim_len == '0)
                        op.status = ST_EMPTY;
                    else if (cmd == CMD_POP)
                        fill_next[sel] = sel_fill - 1'b1;
                    else
                    begin
                        op.re   = 1'b1;
                        op.addr = slot(sel, sel_fill - 1'b1);
                    end
                end
                default:
                begin
                    if (USE_W'(substack_index) >= use_reg)
                        op.status = ST_NO_SUCH;
                    else if (sel_fill == '0)
                        op.status = ST_EMPTY;
                    else
                        fill_next[sel] = sel_fill - 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SUBSTACKS; i++)
                fill_reg[i] <= '0;
            use_reg  <= '0;
            size_reg <= CFG_W'(1);
        end
        else
        begin
            fill_reg <= fill_next;
            use_reg  <= use_next;
            size_reg <= size_next;
        end
    end

endmodule

[hw/rtl/set_of_stacks_engine.sv]
// Set-of-stacks engine: item store memory, command sequencer, output register.
// A result waits in the result registers and enters the output register once that is free.
// Only one item is in flight: a new item is accepted only after the last result
// is loaded into the output register; a stalled output holds the next result back.
// Reset clears fill counts, chain length and sets the size register to 1;
// the item store is not cleared and needs no clearing pass.
// Depends on sos_pkg and sos_chain.
module set_of_stacks_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sos_pkg::CMD_W-1:0]           cmd,
    input  logic signed [sos_pkg::VALUE_W-1:0]  push_value,
    input  logic [sos_pkg::IDX_W-1:0]           substack_index,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sos_pkg::VALUE_W-1:0]  top_value,
    output logic [sos_pkg::STATUS_W-1:0]        status,
    input  logic                                cfg_wr_en,
    input  logic [sos_pkg::CFG_W-1:0]           cfg_wr_data
);
    import sos_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DONE = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VALUE_W-1:0]  top_value_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_read_reg;
    logic [VALUE_W-1:0]  rdata_reg;
    logic [VALUE_W-1:0]  item_store [STORE_DEPTH];

    logic    accept;
    logic    out_free;
    logic    load;
    sos_op_t op;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign load     = (state_reg == ST_DONE) && out_free;

    sos_chain u_chain (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (accept),
        .cmd            (cmd),
        .substack_index (substack_index),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .op             (op)
    );

    always_ff @(posedge clk)
    begin
        if (op.we)
            item_store[op.addr] <= push_value;
        if (op.re)
            rdata_reg <= item_store[op.addr];
    end

    always_comb
    begin
        state_next = state_reg;
        if (accept)
            state_next = ST_DONE;
        else if (load)
            state_next = ST_IDLE;
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_status_reg <= op.status;
            res_read_reg   <= op.re;
        end
        if (load)
        begin
            top_value_reg <= res_read_reg ? rdata_reg : '0;
            status_reg    <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign top_value = top_value_reg;
    assign status    = status_reg;

endmodule

[hw/rtl/sos_checker.sv]
// Port-level checks for set_of_stacks_engine, attached by bind.
// Depends on sos_pkg.
module sos_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [sos_pkg::VALUE_W-1:0]  top_value,
    input  logic [sos_pkg::STATUS_W-1:0]        status
);
    import sos_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(top_value) && $stable(status))
        else $error("stalled result changed");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while another is in flight");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> ##1 out_valid)
        else $error("result missing two cycles after item");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> top_value == '0)
        else $error("error result carries a nonzero value");

endmodule

bind set_of_stacks_engine sos_checker u_sos_checker (.*);
